// File: design/fdtq_pkg.sv
// Shared constants and controller/datapath interface types for the drop-tail queue model.
`default_nettype none

package fdtq_pkg;

    // Queue storage size and derived widths
    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

    // Field widths
    localparam int LIMIT_W = 7;
    localparam int ARR_W   = 32;
    localparam int SVC_W   = 16;
    localparam int CNT_W   = 32;
    localparam int CLK_W   = 48;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Packed stream widths
    localparam int IN_TDATA_W  = ((ARR_W + SVC_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CNT_W + CNT_W + CLK_W + 7) / 8) * 8;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;     // capture an input request
        logic clk_jump;    // move the clock up to the arrival time
        logic rd_head;     // read the front service time
        logic serve;       // retire the front job
        logic admit_step;  // queue or drop the held job
        logic out_load;    // present the result
    } fdtq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic occ_nz;      // queue holds at least one job
        logic clk_lt_arr;  // clock is below the held arrival time
        logic last;        // held job is the final one
        logic out_busy;    // result register still waits to be taken
    } fdtq_sts_t;

endpackage

`default_nettype wire

// File: design/fdtq_dp.sv
// Datapath: job registers, service-time memory, clock, counters and result register.
`default_nettype none

module fdtq_dp (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire fdtq_pkg::fdtq_cmd_t              cmd,
    output      fdtq_pkg::fdtq_sts_t              sts,
    input  wire logic [fdtq_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                             s_tlast,
    input  wire logic                             cfg_valid,
    input  wire logic [fdtq_pkg::LIMIT_W-1:0]     cfg_data,
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [fdtq_pkg::OUT_TDATA_W-1:0] m_tdata,
    output      logic                             m_tuser,
    output      logic                             m_tlast
);
    import fdtq_pkg::*;

    localparam int CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
    localparam int PAD_W = OUT_TDATA_W - (CNT_W + CNT_W + CLK_W);

    logic [SVC_W-1:0]   mem [QUEUE_DEPTH];
    logic [SVC_W-1:0]   rd_data_reg;

    logic [ARR_W-1:0]   arr_reg;
    logic [SVC_W-1:0]   svc_reg;
    logic               last_reg;

    logic [LIMIT_W-1:0] limit_reg;
    logic [PTR_W-1:0]   head_reg;
    logic [PTR_W-1:0]   tail_reg;
    logic [OCC_W-1:0]   occ_reg;
    logic [CLK_W-1:0]   clk_reg;
    logic [CNT_W-1:0]   served_reg;
    logic [CNT_W-1:0]   dropped_reg;
    logic               admit_reg;

    logic               out_valid_reg;
    logic [CNT_W-1:0]   out_served_reg;
    logic [CNT_W-1:0]   out_dropped_reg;
    logic [CLK_W-1:0]   out_clk_reg;
    logic               out_admit_reg;
    logic               out_last_reg;

    logic [CMP_W-1:0]   eff_limit;
    logic               admit;
    logic [CLK_W:0]     clk_sum;
    logic [CLK_W-1:0]   clk_next;
    logic [PTR_W-1:0]   head_next;
    logic [PTR_W-1:0]   tail_next;

    // Effective limit is capped by the storage depth
    assign eff_limit = (CMP_W'(limit_reg) > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH)
                                                                 : CMP_W'(limit_reg);
    assign admit     = CMP_W'(occ_reg) < eff_limit;

    // Saturating clock advance by the front service time
    assign clk_sum  = {1'b0, clk_reg} + (CLK_W+1)'(rd_data_reg);
    assign clk_next = clk_sum[CLK_W] ? {CLK_W{1'b1}} : clk_sum[CLK_W-1:0];

    // Wrap pointers at the storage depth
    assign head_next = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_next = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);

    // Status toward the controller
    assign sts.occ_nz     = (occ_reg != '0);
    assign sts.clk_lt_arr = clk_reg < CLK_W'(arr_reg);
    assign sts.last       = last_reg;
    assign sts.out_busy   = out_valid_reg && !m_tready;

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            arr_reg  <= s_tdata[ARR_W-1:0];
            svc_reg  <= s_tdata[ARR_W+SVC_W-1:ARR_W];
            last_reg <= s_tlast;
        end
    end

    // Service-time memory: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (cmd.admit_step && admit)
        begin
            mem[tail_reg] <= svc_reg;
        end
        if (cmd.rd_head)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    // Limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Queue state, clock and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            clk_reg     <= '0;
            served_reg  <= '0;
            dropped_reg <= '0;
            admit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clk_jump)
            begin
                clk_reg <= CLK_W'(arr_reg);
            end
            if (cmd.serve)
            begin
                clk_reg  <= clk_next;
                head_reg <= head_next;
                occ_reg  <= occ_reg - OCC_W'(1);
                if (served_reg != {CNT_W{1'b1}})
                begin
                    served_reg <= served_reg + CNT_W'(1);
                end
            end
            if (cmd.admit_step)
            begin
                admit_reg <= admit;
                if (admit)
                begin
                    tail_reg <= tail_next;
                    occ_reg  <= occ_reg + OCC_W'(1);
                end
                else if (dropped_reg != {CNT_W{1'b1}})
                begin
                    dropped_reg <= dropped_reg + CNT_W'(1);
                end
            end
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_served_reg  <= served_reg;
            out_dropped_reg <= dropped_reg;
            out_clk_reg     <= clk_reg;
            out_admit_reg   <= admit_reg;
            out_last_reg    <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_admit_reg;
    assign m_tlast  = out_last_reg;
    generate
        if (PAD_W > 0)
        begin : g_pad
            assign m_tdata = {{PAD_W{1'b0}}, out_clk_reg, out_dropped_reg, out_served_reg};
        end
        else
        begin : g_nopad
            assign m_tdata = {out_clk_reg, out_dropped_reg, out_served_reg};
        end
    endgenerate

    // Occupancy never exceeds the storage depth
    assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= CMP_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    // A job is retired only from a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.serve |-> (occ_reg != '0))
        else $error("serve on empty queue");

    // Simulated time never moves backward
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (clk_reg >= $past(clk_reg)))
        else $error("clock decreased");

endmodule

`default_nettype wire

// File: design/fdtq_ctrl.sv
// Controller: sequences arrival-time serving, admission, drain and result handoff.
`default_nettype none

module fdtq_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire fdtq_pkg::fdtq_sts_t sts,
    output      fdtq_pkg::fdtq_cmd_t cmd
);
    import fdtq_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_CHECK   = 9'b000000010,
        ST_ARR_RD  = 9'b000000100,
        ST_ARR_ADD = 9'b000001000,
        ST_ADMIT   = 9'b000010000,
        ST_DRAIN   = 9'b000100000,
        ST_DRN_RD  = 9'b001000000,
        ST_DRN_ADD = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // Sequence one job per request
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // serve the front while the clock trails the arrival
                if (sts.clk_lt_arr && sts.occ_nz)
                begin
                    state_next = ST_ARR_RD;
                end
                else
                begin
                    cmd.clk_jump = sts.clk_lt_arr;
                    state_next   = ST_ADMIT;
                end
            end
            ST_ARR_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = ST_ARR_ADD;
            end
            ST_ARR_ADD:
            begin
                cmd.serve  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_ADMIT:
            begin
                cmd.admit_step = 1'b1;
                state_next     = sts.last ? ST_DRAIN : ST_DONE;
            end
            ST_DRAIN:
            begin
                state_next = sts.occ_nz ? ST_DRN_RD : ST_DONE;
            end
            ST_DRN_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = ST_DRN_ADD;
            end
            ST_DRN_ADD:
            begin
                cmd.serve  = 1'b1;
                state_next = ST_DRAIN;
            end
            ST_DONE:
            begin
                // hold until the result register is free
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/fcfs_drop_tail_queue_sim.sv
// Top level: FCFS single-server drop-tail queue model with stream ports.
// Sequence: an accepted request first serves jobs while the clock trails its arrival,
// then the job is queued or dropped; a request marked last also drains the queue.
// A new request is taken only in idle, after the result goes to a free result register.
// A serve step: head check, registered read of the service-time memory, 48-bit clock add.
// Reset: asynchronous active low; clears queue, clock and counters, limit returns to 64.
`default_nettype none

module fcfs_drop_tail_queue_sim (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_tdata: job_arrival [31:0], service_time [47:32]
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    input  wire logic [fdtq_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                             s_tlast,
    // m_tdata: served_total [31:0], dropped_total [63:32], clock_now [111:64]
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    output      logic [fdtq_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: admitted
    output      logic                             m_tuser,
    output      logic                             m_tlast,
    input  wire logic                             cfg_valid,
    output      logic                             cfg_ready,
    input  wire logic [fdtq_pkg::LIMIT_W-1:0]     cfg_data
);
    import fdtq_pkg::*;

    fdtq_cmd_t cmd;
    fdtq_sts_t sts;

    assign cfg_ready = 1'b1;

    fdtq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fdtq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
